FILE: sv/nrgp_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC/GGA position parser package
// Shared types and constants for the field front end and the conversion back.
// ----------------------------------------------------------------------------
package nrgp_pkg;

  localparam logic KIND_RMC = 1'b0;
  localparam logic KIND_GGA = 1'b1;

  localparam int unsigned OPQ_DEPTH = 4;
  localparam int unsigned OPQ_AW    = $clog2(OPQ_DEPTH);

  localparam logic [34:0] ANGLE_LIMIT  = 35'd10006666665;
  localparam logic [22:0] SPEED_LIMIT  = 23'd5144444;
  localparam logic [16:0] COURSE_LIMIT = 17'd99999;
  localparam logic [15:0] KNOT_MUL     = 16'd33715;
  // Reciprocal of 60 scaled by 2^36, rounded up; exact for dividends below 2^30.
  localparam logic [30:0] RECIP60      = 31'd1145324613;
  localparam int unsigned RECIP_SHIFT  = 36;

  typedef enum logic [2:0] {
    FK_NONE,
    FK_LAT,
    FK_LAT_HEMI,
    FK_LON,
    FK_LON_HEMI,
    FK_SPEED,
    FK_COURSE
  } field_kind_e;

  typedef struct packed {
    field_kind_e fk;
    logic        kind;
    logic        emit;
    logic        neg;
    logic [19:0] int_part;
    logic [13:0] deg;
    logic [6:0]  mins;
    logic [19:0] frac;
    logic [2:0]  frac_cnt;
    logic [9:0]  frac3;
    logic [6:0]  frac2;
  } field_op_t;

endpackage

FILE: sv/nmea_rmc_gga_position_parser.sv
// ----------------------------------------------------------------------------
// NMEA RMC/GGA position parser
// Byte-serial parser that turns RMC and GGA sentences into fixed-point fixes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle sustained; full rises only if the result
// queue stays unread long enough to back up the field queue.
// Path: a result word is shown once the byte that ends the last needed field
// has passed through the field queue and the three conversion stages.
// Reset: asynchronous and active low; the parser returns to hunting for '$'
// and the stored latitude, longitude and speed read zero.
module nmea_rmc_gga_position_parser #(
  parameter int unsigned FRACTION_DIGITS    = 5,
  parameter int unsigned MAX_INTEGER_DIGITS = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic               sentence_kind_o,
  output logic signed [34:0] latitude_e7_o,
  output logic signed [34:0] longitude_e7_o,
  output logic [22:0]        speed_mm_s_o,
  output logic [16:0]        course_centideg_o
);
  import nrgp_pkg::*;

  // The front end classifies every byte and, when a field of interest ends,
  // hands a compact description of it to the field queue.
  logic      byte_acc;
  logic      op_push, op_pop, opq_empty, opq_full;
  field_op_t op_front, op_head;

  // A word is taken whenever the field queue can absorb the worst case of one
  // field ending on this byte.
  assign full     = opq_full;
  assign byte_acc = push && !full;

  nrgp_front #(
    .FRACTION_DIGITS    (FRACTION_DIGITS),
    .MAX_INTEGER_DIGITS (MAX_INTEGER_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_acc),
    .rx_byte_i    (rx_byte_i),
    .op_valid_o   (op_push),
    .op_o         (op_front)
  );

  nrgp_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .op_i    (op_front),
    .pop_i   (op_pop),
    .op_o    (op_head),
    .empty_o (opq_empty),
    .full_o  (opq_full)
  );

  // The back end converts fields in order, so a hemisphere field always sees
  // the angle that came before it, and holds the result queue.
  nrgp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_valid_i        (!opq_empty),
    .op_i              (op_head),
    .op_pop_o          (op_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .sentence_kind_o   (sentence_kind_o),
    .latitude_e7_o     (latitude_e7_o),
    .longitude_e7_o    (longitude_e7_o),
    .speed_mm_s_o      (speed_mm_s_o),
    .course_centideg_o (course_centideg_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_push |-> !opq_full) else $error("field queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop |-> !opq_empty) else $error("field queue read while empty");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_push |=> !opq_empty) else $error("field queue lost a pushed field");

endmodule

FILE: sv/nrgp_front.sv
// ----------------------------------------------------------------------------
// NMEA parser front end
// Matches the header, counts fields and gathers the digits of each field.
// ----------------------------------------------------------------------------
module nrgp_front #(
  parameter int unsigned FRACTION_DIGITS    = 5,
  parameter int unsigned MAX_INTEGER_DIGITS = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          rx_byte_i,
  output logic                op_valid_o,
  output nrgp_pkg::field_op_t op_o
);
  import nrgp_pkg::*;

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned r;
    r = 1;
    for (int unsigned i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  localparam logic [19:0] IntLimit = 20'(pow10(MAX_INTEGER_DIGITS) - 1);
  localparam logic [13:0] DegLimit = 14'(pow10(MAX_INTEGER_DIGITS - 2) - 1);
  localparam logic [2:0]  FracMax  = 3'(FRACTION_DIGITS);

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSouth  = 8'h53;
  localparam logic [7:0] ChWest   = 8'h57;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_FIELDS
  } phase_e;

  function automatic logic [7:0] hdr_rmc(input logic [2:0] pos);
    case (pos)
      3'd0:    return 8'h47;
      3'd1:    return 8'h4E;
      3'd2:    return 8'h52;
      3'd3:    return 8'h4D;
      default: return 8'h43;
    endcase
  endfunction

  function automatic logic [7:0] hdr_gga(input logic [2:0] pos);
    case (pos)
      3'd0:    return 8'h47;
      3'd1:    return 8'h4E;
      3'd2:    return 8'h47;
      3'd3:    return 8'h47;
      default: return 8'h41;
    endcase
  endfunction

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [1:0]  cand_q, cand_d;
  logic [3:0]  field_q, field_d;
  logic        kind_q, kind_d;
  logic [19:0] int_q, int_d;
  logic [13:0] deg_q, deg_d;
  logic [3:0]  tens_q, tens_d;
  logic [3:0]  ones_q, ones_d;
  logic [19:0] frac_q, frac_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [9:0]  frac3_q, frac3_d;
  logic [6:0]  frac2_q, frac2_d;
  logic        point_q, point_d;
  logic [1:0]  hlen_q, hlen_d;
  logic        hmatch_q, hmatch_d;

  field_kind_e fk;
  logic        is_end, is_term, is_digit;
  logic [3:0]  dig;
  logic [23:0] int_next;
  logic [1:0]  cand_new;
  logic [3:0]  last_field;

  always_comb begin
    fk = FK_NONE;
    if (kind_q == KIND_RMC) begin
      case (field_q)
        4'd3:    fk = FK_LAT;
        4'd4:    fk = FK_LAT_HEMI;
        4'd5:    fk = FK_LON;
        4'd6:    fk = FK_LON_HEMI;
        4'd7:    fk = FK_SPEED;
        4'd8:    fk = FK_COURSE;
        default: fk = FK_NONE;
      endcase
    end else begin
      case (field_q)
        4'd2:    fk = FK_LAT;
        4'd3:    fk = FK_LAT_HEMI;
        4'd4:    fk = FK_LON;
        4'd5:    fk = FK_LON_HEMI;
        default: fk = FK_NONE;
      endcase
    end
  end

  assign is_end     = (rx_byte_i == ChStar) || (rx_byte_i == ChCr) || (rx_byte_i == ChLf);
  assign is_term    = is_end || (rx_byte_i == ChComma);
  assign is_digit   = (rx_byte_i >= ChZero) && (rx_byte_i <= ChNine);
  assign dig        = rx_byte_i[3:0];
  assign int_next   = 24'(int_q) * 24'd10 + 24'(dig);
  assign last_field = (kind_q == KIND_RMC) ? 4'd8 : 4'd5;
  assign cand_new   = cand_q & {rx_byte_i == hdr_gga(pos_q), rx_byte_i == hdr_rmc(pos_q)};

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    cand_d   = cand_q;
    field_d  = field_q;
    kind_d   = kind_q;
    int_d    = int_q;
    deg_d    = deg_q;
    tens_d   = tens_q;
    ones_d   = ones_q;
    frac_d   = frac_q;
    cnt_d    = cnt_q;
    frac3_d  = frac3_q;
    frac2_d  = frac2_q;
    point_d  = point_q;
    hlen_d   = hlen_q;
    hmatch_d = hmatch_q;
    op_valid_o = 1'b0;

    op_o.fk       = fk;
    op_o.kind     = kind_q;
    op_o.emit     = (field_q == last_field);
    op_o.neg      = (hlen_q == 2'd1) && hmatch_q;
    op_o.int_part = int_q;
    op_o.deg      = deg_q;
    op_o.mins     = 7'(tens_q) * 7'd10 + 7'(ones_q);
    op_o.frac     = frac_q;
    op_o.frac_cnt = cnt_q;
    op_o.frac3    = frac3_q;
    op_o.frac2    = frac2_q;

    if (byte_valid_i) begin
      if (rx_byte_i == ChDollar) begin
        phase_d = PH_HEADER;
        pos_d   = 3'd0;
        cand_d  = 2'b11;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (pos_q < 3'd5) begin
              if (cand_new == 2'b00) begin
                phase_d = PH_HUNT;
              end else begin
                cand_d = cand_new;
                pos_d  = pos_q + 3'd1;
              end
            end else if (rx_byte_i == ChComma) begin
              phase_d = PH_FIELDS;
              kind_d  = cand_q[0] ? KIND_RMC : KIND_GGA;
              field_d = 4'd1;
            end else begin
              phase_d = PH_HUNT;
            end
          end
          PH_FIELDS: begin
            if (is_term) begin
              op_valid_o = (fk != FK_NONE);
              if (field_q == last_field || is_end) begin
                phase_d = PH_HUNT;
              end else if (field_q < 4'd15) begin
                field_d = field_q + 4'd1;
              end
            end else if (fk == FK_LAT_HEMI || fk == FK_LON_HEMI) begin
              if (hlen_q == 2'd0 &&
                  rx_byte_i == ((fk == FK_LAT_HEMI) ? ChSouth : ChWest)) begin
                hmatch_d = 1'b1;
              end
              if (hlen_q < 2'd2) hlen_d = hlen_q + 2'd1;
            end else if (fk != FK_NONE) begin
              if (is_digit) begin
                if (!point_q) begin
                  if (int_next > 24'(IntLimit)) begin
                    int_d  = IntLimit;
                    deg_d  = DegLimit;
                    tens_d = 4'd9;
                    ones_d = 4'd9;
                  end else begin
                    int_d  = int_next[19:0];
                    deg_d  = 14'(deg_q * 14'd10) + 14'(tens_q);
                    tens_d = ones_q;
                    ones_d = dig;
                  end
                end else if (cnt_q < FracMax) begin
                  frac_d = 20'(frac_q * 20'd10) + 20'(dig);
                  cnt_d  = cnt_q + 3'd1;
                  if (cnt_q < 3'd3) frac3_d = 10'(frac3_q * 10'd10) + 10'(dig);
                  if (cnt_q < 3'd2) frac2_d = 7'(frac2_q * 7'd10) + 7'(dig);
                end
              end else if (rx_byte_i == ChPoint) begin
                point_d = 1'b1;
              end
            end
          end
          default: phase_d = PH_HUNT;
        endcase
      end

      // Every field starts from empty accumulators.
      if (phase_d == PH_FIELDS && (phase_q != PH_FIELDS || is_term)) begin
        int_d    = '0;
        deg_d    = '0;
        tens_d   = '0;
        ones_d   = '0;
        frac_d   = '0;
        cnt_d    = '0;
        frac3_d  = '0;
        frac2_d  = '0;
        point_d  = 1'b0;
        hlen_d   = '0;
        hmatch_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      pos_q    <= '0;
      cand_q   <= 2'b11;
      field_q  <= '0;
      kind_q   <= KIND_RMC;
      int_q    <= '0;
      deg_q    <= '0;
      tens_q   <= '0;
      ones_q   <= '0;
      frac_q   <= '0;
      cnt_q    <= '0;
      frac3_q  <= '0;
      frac2_q  <= '0;
      point_q  <= 1'b0;
      hlen_q   <= '0;
      hmatch_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      cand_q   <= cand_d;
      field_q  <= field_d;
      kind_q   <= kind_d;
      int_q    <= int_d;
      deg_q    <= deg_d;
      tens_q   <= tens_d;
      ones_q   <= ones_d;
      frac_q   <= frac_d;
      cnt_q    <= cnt_d;
      frac3_q  <= frac3_d;
      frac2_q  <= frac2_d;
      point_q  <= point_d;
      hlen_q   <= hlen_d;
      hmatch_q <= hmatch_d;
    end
  end

endmodule

FILE: sv/nrgp_opq.sv
// ----------------------------------------------------------------------------
// NMEA parser field queue
// Short queue of finished fields between the front end and the back end.
// ----------------------------------------------------------------------------
module nrgp_opq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  nrgp_pkg::field_op_t op_i,
  input  logic                pop_i,
  output nrgp_pkg::field_op_t op_o,
  output logic                empty_o,
  output logic                full_o
);
  import nrgp_pkg::*;

  field_op_t         mem_q [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_q, rd_q;
  logic [OPQ_AW:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (OPQ_AW+1)'(OPQ_DEPTH));
  assign op_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (OPQ_AW+1)'(push_i) - (OPQ_AW+1)'(pop_i);
    end
  end

endmodule

FILE: sv/nrgp_back.sv
// ----------------------------------------------------------------------------
// NMEA parser conversion back end
// Three-stage unit scaling fields to fixed point, with a two-word result queue.
// ----------------------------------------------------------------------------
module nrgp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  nrgp_pkg::field_op_t op_i,
  output logic                op_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic                sentence_kind_o,
  output logic signed [34:0]  latitude_e7_o,
  output logic signed [34:0]  longitude_e7_o,
  output logic [22:0]         speed_mm_s_o,
  output logic [16:0]         course_centideg_o
);
  import nrgp_pkg::*;

  typedef struct packed {
    field_kind_e fk;
    logic        kind;
    logic        emit;
    logic        neg;
  } tag_t;

  typedef struct packed {
    logic        kind;
    logic [34:0] lat;
    logic [34:0] lon;
    logic [22:0] speed;
    logic [16:0] course;
  } result_t;

  logic        s1_v_q, s2_v_q, s3_v_q;
  tag_t        s1_tag_q, s2_tag_q, s3_tag_q;
  logic [29:0] s1_x_q;
  logic [36:0] s1_deg_q, s2_deg_q;
  logic [29:0] s1_milli_q;
  logic [26:0] s1_centi_q;
  logic [60:0] s2_prod_q;
  logic [45:0] s2_spd_q;
  logic [16:0] s2_course_q, s3_course_q;
  logic [34:0] s3_angle_q;
  logic [22:0] s3_speed_q;

  logic [34:0] lat_q, lon_q, lat_n, lon_n;
  logic [22:0] speed_q, speed_n;

  result_t     res_q [2];
  logic        res_wr_q, res_rd_q;
  logic [1:0]  res_cnt_q;
  logic        res_full, res_push, res_pop, adv;
  result_t     res_new;

  logic [23:0] p7;
  logic [9:0]  p3;
  logic [6:0]  p2;
  logic [37:0] angle_sum;
  logic [29:0] speed_raw;

  assign res_full = (res_cnt_q == 2'd2);
  assign adv      = !(s3_v_q && s3_tag_q.emit && res_full);
  assign op_pop_o = adv && op_valid_i;
  assign res_push = adv && s3_v_q && s3_tag_q.emit;
  assign res_pop  = pop_i && !empty_o;
  assign empty_o  = (res_cnt_q == 2'd0);

  // Scale of the kept fraction digits up to 10^-7, 10^-3 and 10^-2.
  always_comb begin
    case (op_i.frac_cnt)
      3'd0:    p7 = 24'd10000000;
      3'd1:    p7 = 24'd1000000;
      3'd2:    p7 = 24'd100000;
      3'd3:    p7 = 24'd10000;
      3'd4:    p7 = 24'd1000;
      3'd5:    p7 = 24'd100;
      default: p7 = 24'd10;
    endcase
    case (op_i.frac_cnt)
      3'd0:    p3 = 10'd1000;
      3'd1:    p3 = 10'd100;
      3'd2:    p3 = 10'd10;
      default: p3 = 10'd1;
    endcase
    case (op_i.frac_cnt)
      3'd0:    p2 = 7'd100;
      3'd1:    p2 = 7'd10;
      default: p2 = 7'd1;
    endcase
  end

  assign angle_sum = 38'(s2_deg_q) + 38'(s2_prod_q[60:RECIP_SHIFT]);
  assign speed_raw = s2_spd_q[45:16];

  always_comb begin
    lat_n   = lat_q;
    lon_n   = lon_q;
    speed_n = speed_q;
    if (s3_v_q) begin
      case (s3_tag_q.fk)
        FK_LAT:      lat_n = s3_angle_q;
        FK_LON:      lon_n = s3_angle_q;
        FK_LAT_HEMI: if (s3_tag_q.neg) lat_n = 35'(0) - lat_q;
        FK_LON_HEMI: if (s3_tag_q.neg) lon_n = 35'(0) - lon_q;
        FK_SPEED:    speed_n = s3_speed_q;
        default:     ;
      endcase
    end
    res_new.kind   = s3_tag_q.kind;
    res_new.lat    = lat_n;
    res_new.lon    = lon_n;
    res_new.speed  = (s3_tag_q.kind == KIND_RMC) ? speed_n : '0;
    res_new.course = (s3_tag_q.kind == KIND_RMC && s3_tag_q.fk == FK_COURSE) ?
                     s3_course_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q   <= '{fk: op_i.fk, kind: op_i.kind, emit: op_i.emit, neg: op_i.neg};
      s1_x_q     <= 30'(op_i.mins) * 30'd10000000 + 30'(op_i.frac) * 30'(p7) + 30'd30;
      s1_deg_q   <= 37'(op_i.deg) * 37'd10000000;
      s1_milli_q <= 30'(op_i.int_part) * 30'd1000 + 30'(op_i.frac3) * 30'(p3);
      s1_centi_q <= 27'(op_i.int_part) * 27'd100 + 27'(op_i.frac2) * 27'(p2);

      s2_tag_q    <= s1_tag_q;
      s2_prod_q   <= 61'(s1_x_q) * 61'(RECIP60);
      s2_deg_q    <= s1_deg_q;
      s2_spd_q    <= 46'(s1_milli_q) * 46'(KNOT_MUL);
      s2_course_q <= (s1_centi_q > 27'(COURSE_LIMIT)) ? COURSE_LIMIT : s1_centi_q[16:0];

      s3_tag_q    <= s2_tag_q;
      s3_angle_q  <= (angle_sum > 38'(ANGLE_LIMIT)) ? ANGLE_LIMIT : angle_sum[34:0];
      s3_speed_q  <= (speed_raw > 30'(SPEED_LIMIT)) ? SPEED_LIMIT : speed_raw[22:0];
      s3_course_q <= s2_course_q;
    end
    if (res_push) res_q[res_wr_q] <= res_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      lat_q     <= '0;
      lon_q     <= '0;
      speed_q   <= '0;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      if (adv) begin
        s1_v_q  <= op_valid_i;
        s2_v_q  <= s1_v_q;
        s3_v_q  <= s2_v_q;
        lat_q   <= lat_n;
        lon_q   <= lon_n;
        speed_q <= speed_n;
      end
      if (res_push) res_wr_q <= ~res_wr_q;
      if (res_pop)  res_rd_q <= ~res_rd_q;
      res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  assign sentence_kind_o   = res_q[res_rd_q].kind;
  assign latitude_e7_o     = res_q[res_rd_q].lat;
  assign longitude_e7_o    = res_q[res_rd_q].lon;
  assign speed_mm_s_o      = res_q[res_rd_q].speed;
  assign course_centideg_o = res_q[res_rd_q].course;

endmodule
